[rtl/lehft_pkg.sv]
// Package for the log event header field tagger: character codes, field tags,
// status codes and the result group types shared by the RTL modules.
// No dependencies.
package lehft_pkg;

   localparam int unsigned MaxResults = 5;
   localparam int unsigned HeldDepth  = 4;
   localparam int unsigned PosSat     = 42;

   localparam int unsigned LastColonIndex            = 41;
   localparam int unsigned MinimumEventAllowedLength = 4;
   localparam int unsigned LocationOffset            = 2;
   // Byte position at which the short form decides between the two origin forms.
   localparam int unsigned FormDecidePos = LocationOffset + HeldDepth;

   localparam logic [7:0] CharColon        = 8'h3A;
   localparam logic [7:0] CharOpenBracket  = 8'h5B;
   localparam logic [7:0] CharCloseBracket = 8'h5D;
   localparam logic [7:0] CharCloseParen   = 8'h29;
   localparam logic [7:0] CharDash         = 8'h2D;
   localparam logic [7:0] CharGreater      = 8'h3E;

   localparam logic [2:0] TagQueue  = 3'd0;
   localparam logic [2:0] TagId     = 3'd1;
   localparam logic [2:0] TagName   = 3'd2;
   localparam logic [2:0] TagIp     = 3'd3;
   localparam logic [2:0] TagOrigin = 3'd4;
   localparam logic [2:0] TagLog    = 3'd5;

   localparam logic [1:0] StatusOk        = 2'd0;
   localparam logic [1:0] StatusTooShort  = 2'd1;
   localparam logic [1:0] StatusNoColon   = 2'd2;
   localparam logic [1:0] StatusMissDelim = 2'd3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] field_tag;
      logic       has_byte;
   } lehft_slot_type;

   // All results caused by one input beat; the last one carries done and status.
   typedef struct packed {
      lehft_slot_type [MaxResults-1:0] slot;
      logic [2:0]                      count;
      logic                            done;
      logic [1:0]                      status;
   } lehft_group_type;

endpackage

[rtl/lehft_if.sv]
// Valid/ready channel interfaces for the request and response sides of the
// log event header field tagger. Depends on lehft_pkg.
interface lehft_req_if;
   import lehft_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_event;

   modport source (output valid, output in_byte, output end_of_event, input ready);
   modport sink   (input valid, input in_byte, input end_of_event, output ready);
endinterface

interface lehft_rsp_if;
   import lehft_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] field_tag;
   logic       has_byte;
   logic       event_done;
   logic [1:0] status;

   modport source (output valid, output out_byte, output field_tag, output has_byte,
                   output event_done, output status, input ready);
   modport sink   (input valid, input out_byte, input field_tag, input has_byte,
                   input event_done, input status, output ready);
endinterface

[rtl/log_event_header_field_tagger.sv]
// Top level of the log event header field tagger: request input register,
// result group register and the drain that emits one result per beat.
// Depends on lehft_pkg, lehft_if and lehft_parse.
//
// Usage. The request channel (req_if) carries one character of a log event per
// beat, with end_of_event set on the event's last character. The response
// channel (rsp_if) carries tagged field characters, one per beat; the beat that
// closes an event has event_done set and carries the event status, and is a
// status-only beat (has_byte low) when the last character yields no field byte.
//
// Structure. An accepted beat lands in an input register. From there the parser
// works out, combinationally, every result that character causes (up to five, when
// held short-form bytes are flushed) and loads them into a group register. The
// group is drained one result per cycle while the receiver is ready. The input
// register refills while the group is still draining, so the two sides are decoupled.
//
// Flow. A character is accepted into the input register and its results are
// registered in the group register. One character is accepted per cycle as long
// as each causes at most one result and the receiver is ready; a character that
// causes several results holds the group register until all have been drained.
//
// Reset is synchronous and active high; it empties both registers and returns
// the parser to the start of an event. When the receiver stalls, the current
// result holds, the group and input registers fill, and req_if.ready then falls.
module log_event_header_field_tagger (
   input logic         clock,
   input logic         reset,
   lehft_req_if.sink   req_if,
   lehft_rsp_if.source rsp_if
);
   import lehft_pkg::*;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // Result group register and drain index.
   logic            grp_valid_ff, grp_valid_in;
   lehft_group_type grp_ff, grp_in;
   logic [2:0]      idx_ff, idx_in;

   lehft_group_type step_group;
   lehft_slot_type  cur_slot;
   logic            last_slot;
   logic            rsp_beat;
   logic            grp_free;
   logic            step_en;

   assign cur_slot  = grp_ff.slot[idx_ff];
   assign last_slot = (idx_ff == grp_ff.count - 3'd1);
   assign rsp_beat  = rsp_if.valid && rsp_if.ready;
   // The group register can take a new group once its last result is leaving.
   assign grp_free  = !grp_valid_ff || (rsp_beat && last_slot);
   assign step_en   = in_valid_ff && grp_free;

   assign req_if.ready = !in_valid_ff || step_en;

   lehft_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .in_byte      (in_byte_ff),
      .end_of_event (in_end_ff),
      .step_group   (step_group)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      grp_valid_in = grp_valid_ff;
      grp_in       = grp_ff;
      idx_in       = idx_ff;

      if (req_if.valid && req_if.ready) in_valid_in = 1'b1;
      else if (step_en)                 in_valid_in = 1'b0;

      if (step_en) begin
         // A character that causes no result leaves the group register empty.
         grp_valid_in = (step_group.count != 3'd0);
         grp_in       = step_group;
         idx_in       = '0;
      end else if (rsp_beat) begin
         if (last_slot) grp_valid_in = 1'b0;
         else           idx_in       = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         grp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         grp_valid_ff <= grp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.in_byte;
         in_end_ff  <= req_if.end_of_event;
      end
      grp_ff <= grp_in;
   end

   assign rsp_if.valid      = grp_valid_ff;
   assign rsp_if.out_byte   = cur_slot.out_byte;
   assign rsp_if.field_tag  = cur_slot.field_tag;
   assign rsp_if.has_byte   = cur_slot.has_byte;
   assign rsp_if.event_done = grp_ff.done && last_slot;
   assign rsp_if.status     = (grp_ff.done && last_slot) ? grp_ff.status : StatusOk;

`ifndef SYNTHESIS
   a_group_count: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> grp_ff.count != 3'd0 && grp_ff.count <= 3'(MaxResults))
      else $error("group register holds an empty or oversized group");
   a_drain_index: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> idx_ff < grp_ff.count)
      else $error("drain index beyond group");
   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.event_done |-> rsp_if.status == StatusOk)
      else $error("status on a result that does not close an event");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_if.ready)
      else $error("request side stalled with empty input register");
`endif
endmodule

[rtl/lehft_parse.sv]
// Parser state and per-byte step logic: holds the parse phase, byte position,
// held short-form bytes and event status, and builds the result group.
// Depends on lehft_pkg.
module lehft_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  logic [7:0]                in_byte,
   input  logic                      end_of_event,
   output lehft_pkg::lehft_group_type step_group
);
   import lehft_pkg::*;

   localparam int unsigned HeldIdxW = $clog2(HeldDepth);

   localparam logic [3:0] PhQueue  = 4'd0;
   localparam logic [3:0] PhColon  = 4'd1;
   localparam logic [3:0] PhForm   = 4'd2;
   localparam logic [3:0] PhHold   = 4'd3;
   localparam logic [3:0] PhId     = 4'd4;
   localparam logic [3:0] PhSkipA  = 4'd5;
   localparam logic [3:0] PhSkipB  = 4'd6;
   localparam logic [3:0] PhName   = 4'd7;
   localparam logic [3:0] PhSkipC  = 4'd8;
   localparam logic [3:0] PhIp     = 4'd9;
   localparam logic [3:0] PhOrigin = 4'd10;
   localparam logic [3:0] PhV6     = 4'd11;
   localparam logic [3:0] PhLog    = 4'd12;
   localparam logic [3:0] PhDrop   = 4'd13;

   logic [3:0] phase_ff,  phase_in;
   logic [5:0] pos_ff,    pos_in;
   logic [2:0] cnt_ff,    cnt_in;
   logic [1:0] status_ff, status_in;
   logic [7:0] held_ff [HeldDepth];
   logic [7:0] held_in [HeldDepth];

   function automatic lehft_group_type push(lehft_group_type g, logic [7:0] b,
                                             logic [2:0] tag, logic has);
      lehft_group_type r;
      r = g;
      r.slot[g.count].out_byte  = b;
      r.slot[g.count].field_tag = tag;
      r.slot[g.count].has_byte  = has;
      r.count = g.count + 3'd1;
      return r;
   endfunction

   always_comb begin
      lehft_group_type g;
      logic            colon;
      logic            do_flush;
      logic [1:0]      st;

      g         = '0;
      colon     = 1'b0;
      do_flush  = 1'b0;
      st        = StatusOk;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      held_in   = held_ff;
      pos_in    = (pos_ff < 6'(PosSat)) ? pos_ff + 6'd1 : 6'(PosSat);

      case (phase_ff)
         PhQueue: begin
            g = push(g, in_byte, TagQueue, 1'b1);
            phase_in = PhColon;
         end
         PhColon: begin
            if (in_byte == CharColon) begin
               phase_in = PhForm;
            end else begin
               status_in = StatusNoColon;
               phase_in  = PhDrop;
            end
         end
         PhForm: begin
            if (in_byte == CharOpenBracket) begin
               phase_in = PhId;
            end else begin
               held_in[0] = in_byte;
               cnt_in     = 3'd1;
               phase_in   = PhHold;
               // An event that ends here is released as IPv4 straight away.
               do_flush   = end_of_event;
            end
         end
         PhHold: begin
            if (pos_ff < 6'(FormDecidePos)) begin
               if (cnt_ff < 3'(HeldDepth)) begin
                  held_in[cnt_ff[HeldIdxW-1:0]] = in_byte;
                  cnt_in = cnt_ff + 3'd1;
               end
               do_flush = end_of_event;
            end else if (in_byte == CharColon) begin
               // Colon at byte six: fixed-length IPv6 origin.
               for (int i = 0; i < HeldDepth; i++) begin
                  if (i < int'(cnt_ff)) begin
                     g = push(g, held_ff[i[HeldIdxW-1:0]], TagOrigin, 1'b1);
                  end
               end
               cnt_in   = 3'd0;
               g        = push(g, in_byte, TagOrigin, 1'b1);
               phase_in = PhV6;
            end else begin
               do_flush = 1'b1;
            end
         end
         PhId: begin
            if (in_byte == CharCloseBracket) phase_in = PhSkipA;
            else g = push(g, in_byte, TagId, 1'b1);
         end
         PhSkipA: phase_in = PhSkipB;
         PhSkipB: phase_in = PhName;
         PhName: begin
            if (in_byte == CharCloseParen) phase_in = PhSkipC;
            else g = push(g, in_byte, TagName, 1'b1);
         end
         PhSkipC: phase_in = PhIp;
         PhIp: begin
            // A held dash is either half of the arrow or an address character.
            if (cnt_ff != 3'd0 && in_byte == CharGreater) begin
               cnt_in   = 3'd0;
               phase_in = PhOrigin;
            end else begin
               if (cnt_ff != 3'd0) g = push(g, CharDash, TagIp, 1'b1);
               if (in_byte == CharDash) begin
                  cnt_in = 3'd1;
               end else begin
                  cnt_in = 3'd0;
                  g = push(g, in_byte, TagIp, 1'b1);
               end
            end
         end
         PhOrigin: begin
            if (in_byte == CharColon) phase_in = PhLog;
            else g = push(g, in_byte, TagOrigin, 1'b1);
         end
         PhV6: begin
            if (pos_ff >= 6'(LastColonIndex)) phase_in = PhLog;
            else g = push(g, in_byte, TagOrigin, 1'b1);
         end
         PhLog: g = push(g, in_byte, TagLog, 1'b1);
         default: ;
      endcase

      if (do_flush) begin
         // IPv4 form: origin runs to the first colon among the held bytes.
         for (int i = 0; i < HeldDepth; i++) begin
            if (i < int'(cnt_in)) begin
               if (colon) g = push(g, held_in[i[HeldIdxW-1:0]], TagLog, 1'b1);
               else if (held_in[i[HeldIdxW-1:0]] == CharColon) colon = 1'b1;
               else g = push(g, held_in[i[HeldIdxW-1:0]], TagOrigin, 1'b1);
            end
         end
         cnt_in = 3'd0;
         if (pos_ff >= 6'(FormDecidePos)) begin
            g = push(g, in_byte, colon ? TagLog : TagOrigin, 1'b1);
         end
         phase_in = colon ? PhLog : PhOrigin;
      end

      if (end_of_event) begin
         if (phase_in == PhIp && cnt_in != 3'd0) g = push(g, CharDash, TagIp, 1'b1);
         if (pos_ff < 6'(MinimumEventAllowedLength)) st = StatusTooShort;
         else if (status_in != StatusOk)            st = status_in;
         else if (phase_in == PhLog)                st = StatusOk;
         else if (phase_in == PhV6)                 st = StatusTooShort;
         else                                       st = StatusMissDelim;
         if (g.count == 3'd0) g = push(g, 8'h00, TagQueue, 1'b0);
         g.done    = 1'b1;
         g.status  = st;
         phase_in  = PhQueue;
         pos_in    = '0;
         cnt_in    = '0;
         status_in = StatusOk;
      end

      step_group = g;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PhQueue;
         pos_ff    <= '0;
         cnt_ff    <= '0;
         status_ff <= StatusOk;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) held_ff <= held_in;
   end

`ifndef SYNTHESIS
   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= 6'(PosSat)) else $error("byte position beyond saturation");
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(HeldDepth)) else $error("held count beyond store depth");
   a_event_restart: assert property (@(posedge clock) disable iff (reset)
      step_en && end_of_event |=> phase_ff == PhQueue && pos_ff == 6'd0
                                  && cnt_ff == 3'd0 && status_ff == StatusOk)
      else $error("parser not back at queue phase after event end");
   a_group_nonempty_end: assert property (@(posedge clock) disable iff (reset)
      end_of_event |-> step_group.count != 3'd0 && step_group.done)
      else $error("event end produced no result");
`endif
endmodule

[test/log_event_header_field_tagger_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the log event header field tagger: drives event text
// into the request channel and checks every tagged response beat against a predictor.
// Depends on lehft_pkg, lehft_if and the log_event_header_field_tagger RTL.
module log_event_header_field_tagger_test;
   import lehft_pkg::*;

   // Run shape. The item count only decides when the random stimulus stops.
   localparam int unsigned RandomItems = 100;
   localparam int unsigned QuietTail   = 30;
   localparam int unsigned LongHold    = 200;
   localparam int unsigned DrainCycles = 10;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned ShowLimit   = 10;

   // One response beat as the checker sees it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] field_tag;
      logic       has_byte;
      logic       event_done;
      logic [1:0] status;
   } tagged_char_type;

   localparam tagged_char_type NoResult = '0;

   // Where the parser stands within the current event.
   typedef enum logic [3:0] {
      StQueue, StColon, StForm, StHold, StId, StSkipA, StSkipB, StName, StSkipC,
      StIp, StOrigin, StV6, StLog, StDrop
   } parse_state_type;

   // One row of the directed stimulus. Where typed is set, the expected beat is
   // written into the row (yields says whether there is one at all); otherwise
   // the predictor supplies it.
   typedef struct packed {
      logic [7:0]      chr;
      logic            last;
      logic            typed;
      logic            yields;
      tagged_char_type result;
   } stim_row_type;

   localparam stim_row_type DirectedRows [26] = '{
      // A lone byte is an event that is far too short; it still carries its queue id.
      '{8'hFF, 1'b1, 1'b1, 1'b1, '{8'hFF, TagQueue, 1'b1, 1'b1, StatusTooShort}},
      // Byte 1 is not a colon, so everything after the queue id is dropped and the
      // closing beat is a status-only one.
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, TagQueue, 1'b1, 1'b0, StatusOk}},
      '{8'h3B, 1'b0, 1'b1, 1'b0, NoResult},
      '{8'h80, 1'b0, 1'b1, 1'b0, NoResult},
      '{8'h01, 1'b0, 1'b1, 1'b0, NoResult},
      '{8'hFE, 1'b1, 1'b1, 1'b1, '{8'h00, TagQueue, 1'b0, 1'b1, StatusNoColon}},
      // Full form with empty id and name, a lone dash inside the address and then
      // the arrow: "Q:[] () -x->o:g".
      '{8'h51, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharColon, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharOpenBracket, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharCloseBracket, 1'b0, 1'b0, 1'b0, NoResult},
      '{8'h20, 1'b0, 1'b0, 1'b0, NoResult},
      '{8'h28, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharCloseParen, 1'b0, 1'b0, 1'b0, NoResult},
      '{8'h20, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharDash, 1'b0, 1'b0, 1'b0, NoResult},
      '{8'h78, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharDash, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharGreater, 1'b0, 1'b0, 1'b0, NoResult},
      '{8'h6F, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharColon, 1'b0, 1'b0, 1'b0, NoResult},
      '{8'h67, 1'b1, 1'b0, 1'b0, NoResult},
      // Short form that ends at byte 4 while still holding: treated as IPv4, and the
      // colon among the held bytes closes the origin.
      '{8'h71, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharColon, 1'b0, 1'b0, 1'b0, NoResult},
      '{8'h61, 1'b0, 1'b0, 1'b0, NoResult},
      '{8'h62, 1'b0, 1'b0, 1'b0, NoResult},
      '{CharColon, 1'b1, 1'b0, 1'b0, NoResult}
   };

   logic clock;
   logic reset;

   lehft_req_if req_chan ();
   lehft_rsp_if rsp_chan ();

   log_event_header_field_tagger u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   // Predictor state: a private copy of the parser, advanced once per accepted beat.
   parse_state_type tagger_state;
   int unsigned     char_pos;
   logic [7:0]      held_chars [HeldDepth];
   int unsigned     held_num;
   logic [1:0]      sticky_status;
   tagged_char_type char_results [$];

   // Beats still owed by the block, oldest first.
   tagged_char_type expected_tags [$];
   // Text of the random event being sent.
   logic [7:0]      event_text [$];

   int unsigned  mismatch_count;
   int unsigned  cycle_count;
   // Idling on both sides is switched off for the last stretch of the run.
   bit           gaps_on;
   // Set once the random part begins; the receiver then holds off once, at length.
   bit           hold_armed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic tagged_char_type field_char(input logic [7:0] c,
                                                  input logic [2:0] tag);
      tagged_char_type r;
      r           = '0;
      r.out_byte  = c;
      r.field_tag = tag;
      r.has_byte  = 1'b1;
      return r;
   endfunction

   // Appends one beat to those caused by the current character.
   function automatic void add_result(input tagged_char_type r);
      char_results = {char_results, r};
   endfunction

   function automatic void reset_tagger();
      tagger_state  = StQueue;
      char_pos      = 0;
      held_num      = 0;
      sticky_status = StatusOk;
      foreach (held_chars[i]) held_chars[i] = '0;
   endfunction

   // Releases the short-form bytes held so far as IPv4: origin up to the first colon,
   // log after it. Returns whether a colon was among them.
   function automatic logic flush_held();
      logic colon_seen;
      colon_seen = 1'b0;
      for (int i = 0; i < held_num && i < HeldDepth; i++) begin
         if (colon_seen) begin
            add_result(field_char(held_chars[i], TagLog));
         end else if (held_chars[i] == CharColon) begin
            colon_seen = 1'b1;
         end else begin
            add_result(field_char(held_chars[i], TagOrigin));
         end
      end
      held_num = 0;
      return colon_seen;
   endfunction

   // Works out every beat that one accepted character causes, into char_results.
   task automatic predict_char(input logic [7:0] c, input logic last);
      int unsigned     pos;
      logic [1:0]      st;
      tagged_char_type closing;
      pos = char_pos;
      char_results.delete();
      case (tagger_state)
         StQueue: begin
            add_result(field_char(c, TagQueue));
            tagger_state = StColon;
         end
         StColon: begin
            if (c == CharColon) begin
               tagger_state = StForm;
            end else begin
               sticky_status = StatusNoColon;
               tagger_state  = StDrop;
            end
         end
         StForm: begin
            if (c == CharOpenBracket) begin
               tagger_state = StId;
            end else begin
               held_chars[0] = c;
               held_num      = 1;
               tagger_state  = StHold;
            end
         end
         StHold: begin
            if (pos < FormDecidePos) begin
               if (held_num < HeldDepth) begin
                  held_chars[held_num] = c;
                  held_num++;
               end
            end else if (c == CharColon) begin
               // A colon at byte 6 means IPv6: the held bytes are all origin.
               for (int i = 0; i < held_num && i < HeldDepth; i++) begin
                  add_result(field_char(held_chars[i], TagOrigin));
               end
               held_num = 0;
               add_result(field_char(c, TagOrigin));
               tagger_state = StV6;
            end else if (flush_held()) begin
               add_result(field_char(c, TagLog));
               tagger_state = StLog;
            end else begin
               add_result(field_char(c, TagOrigin));
               tagger_state = StOrigin;
            end
         end
         StId: begin
            if (c == CharCloseBracket) tagger_state = StSkipA;
            else add_result(field_char(c, TagId));
         end
         StSkipA: tagger_state = StSkipB;
         StSkipB: tagger_state = StName;
         StName: begin
            if (c == CharCloseParen) tagger_state = StSkipC;
            else add_result(field_char(c, TagName));
         end
         StSkipC: tagger_state = StIp;
         StIp: begin
            if (held_num != 0 && c == CharGreater) begin
               // The held dash and this byte form the arrow; both are dropped.
               held_num     = 0;
               tagger_state = StOrigin;
            end else begin
               if (held_num != 0) begin
                  held_num = 0;
                  add_result(field_char(CharDash, TagIp));
               end
               if (c == CharDash) begin
                  held_chars[0] = c;
                  held_num      = 1;
               end else begin
                  add_result(field_char(c, TagIp));
               end
            end
         end
         StOrigin: begin
            if (c == CharColon) tagger_state = StLog;
            else add_result(field_char(c, TagOrigin));
         end
         StV6: begin
            if (pos >= LastColonIndex) tagger_state = StLog;
            else add_result(field_char(c, TagOrigin));
         end
         StLog: add_result(field_char(c, TagLog));
         default: ;
      endcase

      if (!last) begin
         char_pos = (pos < PosSat) ? pos + 1 : PosSat;
      end else begin
         if (tagger_state == StHold) tagger_state = flush_held() ? StLog : StOrigin;
         if (tagger_state == StIp && held_num != 0) begin
            add_result(field_char(CharDash, TagIp));
         end
         if (pos < MinimumEventAllowedLength) st = StatusTooShort;
         else if (sticky_status != StatusOk) st = sticky_status;
         else if (tagger_state == StLog) st = StatusOk;
         else if (tagger_state == StV6) st = StatusTooShort;
         else st = StatusMissDelim;
         if (char_results.size() == 0) add_result(NoResult);
         closing            = char_results.pop_back();
         closing.event_done = 1'b1;
         closing.status     = st;
         add_result(closing);
         reset_tagger();
      end
   endtask

   // Offers one character and waits for the block to take it. The beat's
   // expectations are queued at the edge that accepts it, which is well ahead of
   // the earliest response.
   task automatic drive_char(input logic [7:0] c, input logic last, input logic typed,
                             input logic yields, input tagged_char_type typed_result);
      req_chan.valid        <= 1'b1;
      req_chan.in_byte      <= c;
      req_chan.end_of_event <= last;
      do @(posedge clock); while (!req_chan.ready);
      predict_char(c, last);
      if (typed) begin
         if (yields) expected_tags = {expected_tags, typed_result};
      end else begin
         foreach (char_results[i]) expected_tags = {expected_tags, char_results[i]};
      end
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] any_but(input logic [7:0] excluded);
      logic [7:0] c;
      c = 8'($urandom);
      while (c == excluded) c = 8'($urandom);
      return c;
   endfunction

   // Appends one character to the event being built.
   function automatic void add_text(input logic [7:0] c);
      event_text = {event_text, c};
   endfunction

   // Builds one random event into event_text. Most are well-formed events of one of
   // the three shapes with random content; a few are plain noise, and some are cut
   // short at a random point so that the missing delimiter and too short cases come up.
   task automatic build_event(input int unsigned kind);
      int unsigned cut;
      int unsigned origin_len;
      logic [7:0]  c;
      event_text.delete();
      if (kind < 2) begin
         repeat ($urandom_range(1, 8)) add_text(8'($urandom));
      end else begin
         add_text(8'($urandom));
         add_text(CharColon);
         if (kind < 11) begin
            // Full form: [id] (name) ip->origin:log
            add_text(CharOpenBracket);
            repeat ($urandom_range(0, 3)) add_text(any_but(CharCloseBracket));
            add_text(CharCloseBracket);
            repeat (2) add_text(8'($urandom));
            repeat ($urandom_range(0, 3)) add_text(any_but(CharCloseParen));
            add_text(CharCloseParen);
            add_text(8'($urandom));
            repeat ($urandom_range(0, 4)) begin
               add_text(($urandom_range(0, 2) == 0) ? CharDash : any_but(CharDash));
            end
            add_text(CharDash);
            add_text(CharGreater);
            repeat ($urandom_range(0, 4)) add_text(any_but(CharColon));
            add_text(CharColon);
            repeat ($urandom_range(0, 5)) add_text(8'($urandom));
         end else if (kind < 18) begin
            // Short form, IPv4: origin up to the first colon. An origin of four
            // bytes puts the colon at byte 6 and so looks like IPv6.
            origin_len = $urandom_range(0, 6);
            for (int i = 0; i < origin_len; i++) begin
               c = any_but(CharColon);
               if (i == 0 && c == CharOpenBracket) c = 8'h31;
               add_text(c);
            end
            if ($urandom_range(0, 7) != 0) add_text(CharColon);
            repeat ($urandom_range(0, 5)) add_text(8'($urandom));
         end else begin
            // Short form, IPv6: fixed origin up to byte 40, byte 41 dropped.
            add_text(any_but(CharOpenBracket));
            repeat (3) add_text(8'($urandom));
            add_text(CharColon);
            repeat (LastColonIndex - FormDecidePos) add_text(8'($urandom));
            repeat ($urandom_range(0, 4)) add_text(8'($urandom));
         end
         if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, event_text.size());
            while (event_text.size() > cut) void'(event_text.pop_back());
         end
      end
   endtask

   // Receiver: ready drops in random bursts, and once, early in the random part,
   // for a long stretch so that both internal registers fill and the request
   // side stalls while the sender keeps offering.
   initial begin
      bit held_off;
      held_off = 1'b0;
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_armed && !held_off) begin
            held_off = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Checker: every accepted response beat is compared with the oldest expectation.
   always @(posedge clock) begin
      tagged_char_type seen;
      tagged_char_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.out_byte   = rsp_chan.out_byte;
         seen.field_tag  = rsp_chan.field_tag;
         seen.has_byte   = rsp_chan.has_byte;
         seen.event_done = rsp_chan.event_done;
         seen.status     = rsp_chan.status;
         if (expected_tags.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ShowLimit) begin
               $display("unexpected beat: byte %02h tag %0d has %0b done %0b status %0d",
                        seen.out_byte, seen.field_tag, seen.has_byte, seen.event_done,
                        seen.status);
            end
         end else begin
            want = expected_tags.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= ShowLimit) begin
                  $display("beat mismatch: expected byte %02h tag %0d has %0b done %0b status %0d",
                           want.out_byte, want.field_tag, want.has_byte, want.event_done,
                           want.status);
                  $display("               actual   byte %02h tag %0d has %0b done %0b status %0d",
                           seen.out_byte, seen.field_tag, seen.has_byte, seen.event_done,
                           seen.status);
               end
            end
         end
      end
   end

   // Watchdog: a stuck handshake or a beat that never arrives ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Main sequence: reset, the directed table, then random events, then the drain.
   initial begin
      int unsigned sent;
      mismatch_count = 0;
      cycle_count    = 0;
      gaps_on        = 1'b1;
      hold_armed     = 1'b0;
      reset_tagger();
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.in_byte      <= '0;
      req_chan.end_of_event <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedRows[i]) begin
         drive_char(DirectedRows[i].chr, DirectedRows[i].last, DirectedRows[i].typed,
                    DirectedRows[i].yields, DirectedRows[i].result);
      end

      // The first random event is always built in the IPv6 shape, though it may still be cut
      // short; the long receiver hold-off lands on it.
      hold_armed = 1'b1;
      sent       = 0;
      while (sent < RandomItems) begin
         if (sent + QuietTail >= RandomItems) gaps_on = 1'b0;
         build_event((sent == 0) ? 18 : $urandom_range(0, 19));
         foreach (event_text[i]) begin
            drive_char(event_text[i], i == event_text.size() - 1, 1'b0, 1'b0, NoResult);
         end
         sent += event_text.size();
      end
      req_chan.valid <= 1'b0;

      while (expected_tags.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
